[rtl/parent_table_best_rssi_select_macros.svh]
// Assertion macros shared by the neighbor table RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef PARENT_TABLE_BEST_RSSI_SELECT_MACROS_SVH
`define PARENT_TABLE_BEST_RSSI_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define PTBRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define PTBRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ptbrs_pkg.sv]
// Shared types and constants for the neighbor table / best parent select block.
// No dependencies.
package ptbrs_pkg;

    localparam int ADDR_W = 16;
    localparam int RSSI_W = 16;

    // Function codes of a transaction
    localparam logic FUNC_ADD    = 1'b0;
    localparam logic FUNC_SELECT = 1'b1;

    // Add status codes
    localparam logic [1:0] ADD_UPDATED  = 2'd0;
    localparam logic [1:0] ADD_INSERTED = 2'd1;
    localparam logic [1:0] ADD_FULL     = 2'd2;

    // RSSI value that marks an entry as never eligible
    localparam logic signed [RSSI_W-1:0] RSSI_SENTINEL = 16'sd1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    // Compare unit results for one table entry
    typedef struct packed {
        logic addr_eq;
        logic rssi_ge;
        logic sentinel;
    } t_cmp_res;

endpackage

[rtl/ptbrs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ptbrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/ptbrs_cmp.sv]
// Shared compare unit: checks one table entry against the lookup key and the
// running best RSSI. Depends on ptbrs_pkg.
module ptbrs_cmp
    import ptbrs_pkg::*;
(
    input  logic [ADDR_W-1:0]        i_entry_addr,
    input  logic signed [RSSI_W-1:0] i_entry_rssi,
    input  logic [ADDR_W-1:0]        i_key_addr,
    input  logic signed [RSSI_W-1:0] i_best_rssi,
    output t_cmp_res                 o_res
);

    // Address match for add, signed compare and sentinel check for select
    always_comb begin
        o_res.addr_eq  = (i_entry_addr == i_key_addr);
        o_res.rssi_ge  = (i_entry_rssi >= i_best_rssi);
        o_res.sentinel = (i_entry_rssi == RSSI_SENTINEL);
    end

endmodule

[rtl/parent_table_best_rssi_select.sv]
// Neighbor table with best parent selection.
//
// Usage: present i_func, i_node_addr and i_rssi_value with start high; the
// transaction is taken at a clock edge where start is high and busy is low.
// busy stays high while the table is scanned. One result comes back for every
// transaction: o_done is high for exactly one cycle with o_add_status,
// o_found, o_parent_addr and o_parent_rssi valid. The receiver cannot stall.
// An add (func 0) updates a matching address, else appends it, else reports
// full. A select (func 1) returns the highest RSSI entry, skipping the
// sentinel RSSI of 1, newest entry winning ties.
// Operation: the table RAM is walked once, one entry per cycle through the
// single compare unit, behind the registered RAM read. busy drops in the
// cycle that shows o_done, so the next start can be taken at the edge that
// ends it.
// Reset (i_rst_n low, synchronous) empties the table by clearing the entry
// count; entry storage is not cleared and needs no clearing pass.
// Depends on ptbrs_pkg, ptbrs_cmp, ptbrs_ram and the macros header.
`include "parent_table_best_rssi_select_macros.svh"

module parent_table_best_rssi_select
    import ptbrs_pkg::*;
#(
    parameter int TABLE_DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_func,
    input  logic [ADDR_W-1:0]        i_node_addr,
    input  logic signed [RSSI_W-1:0] i_rssi_value,
    output logic                     o_done,
    output logic [1:0]               o_add_status,
    output logic                     o_found,
    output logic [ADDR_W-1:0]        o_parent_addr,
    output logic signed [RSSI_W-1:0] o_parent_rssi
);

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W = ADDR_W + RSSI_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    t_state r_state, n_state;

    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_rd_cnt, n_rd_cnt;
    logic                      r_dv, n_dv;
    logic [IDX_W-1:0]          r_didx, n_didx;
    logic                      r_func, n_func;
    logic [ADDR_W-1:0]         r_key_addr, n_key_addr;
    logic signed [RSSI_W-1:0]  r_key_rssi, n_key_rssi;
    logic                      r_hit, n_hit;
    logic [IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic                      r_have, n_have;
    logic [ADDR_W-1:0]         r_best_addr, n_best_addr;
    logic signed [RSSI_W-1:0]  r_best_rssi, n_best_rssi;

    logic                      r_done, n_done;
    logic [1:0]                r_add_status, n_add_status;
    logic                      r_found, n_found;
    logic [ADDR_W-1:0]         r_parent_addr, n_parent_addr;
    logic signed [RSSI_W-1:0]  r_parent_rssi, n_parent_rssi;

    logic                      accept;
    logic                      rd_en;
    logic                      we;
    logic [IDX_W-1:0]          waddr;
    logic [DATA_W-1:0]         rdata;
    logic [ADDR_W-1:0]         ent_addr;
    logic signed [RSSI_W-1:0]  ent_rssi;
    t_cmp_res                  cmp;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Issue one table read per cycle while entries remain
    assign rd_en = (r_state == S_SCAN) && (r_rd_cnt < r_count);

    // Entry storage
    ptbrs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata ({r_key_addr, r_key_rssi}),
        .i_re    (rd_en),
        .i_raddr (r_rd_cnt[IDX_W-1:0]),
        .o_rdata (rdata)
    );

    assign ent_addr = rdata[DATA_W-1:RSSI_W];
    assign ent_rssi = rdata[RSSI_W-1:0];

    // Shared compare unit
    ptbrs_cmp u_cmp (
        .i_entry_addr (ent_addr),
        .i_entry_rssi (ent_rssi),
        .i_key_addr   (r_key_addr),
        .i_best_rssi  (r_best_rssi),
        .o_res        (cmp)
    );

    // Table write at finish of an add: update a hit, else append if room
    always_comb begin
        we    = 1'b0;
        waddr = r_hit_idx;
        if ((r_state == S_FIN) && (r_func == FUNC_ADD)) begin
            if (r_hit) begin
                we = 1'b1;
            end else if (r_count < DEPTH_C) begin
                we    = 1'b1;
                waddr = r_count[IDX_W-1:0];
            end
        end
    end

    // Sequencer
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_rd_cnt      = r_rd_cnt;
        n_dv          = rd_en;
        n_didx        = r_rd_cnt[IDX_W-1:0];
        n_func        = r_func;
        n_key_addr    = r_key_addr;
        n_key_rssi    = r_key_rssi;
        n_hit         = r_hit;
        n_hit_idx     = r_hit_idx;
        n_have        = r_have;
        n_best_addr   = r_best_addr;
        n_best_rssi   = r_best_rssi;
        n_done        = 1'b0;
        n_add_status  = r_add_status;
        n_found       = r_found;
        n_parent_addr = r_parent_addr;
        n_parent_rssi = r_parent_rssi;

        // Evaluate the entry whose read data has arrived
        if (r_dv) begin
            if (r_func == FUNC_ADD) begin
                if (cmp.addr_eq && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_didx;
                end
            end else if (!cmp.sentinel && (!r_have || cmp.rssi_ge)) begin
                // Oldest first with >= keeps the newest on ties
                n_have      = 1'b1;
                n_best_addr = ent_addr;
                n_best_rssi = ent_rssi;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state     = S_SCAN;
                    n_rd_cnt    = '0;
                    n_func      = i_func;
                    n_key_addr  = i_node_addr;
                    n_key_rssi  = i_rssi_value;
                    n_hit       = 1'b0;
                    n_have      = 1'b0;
                    n_best_addr = '0;
                    n_best_rssi = RSSI_SENTINEL;
                end
            end
            S_SCAN: begin
                if (rd_en) begin
                    n_rd_cnt = r_rd_cnt + 1'b1;
                end else if (!r_dv) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (r_func == FUNC_ADD) begin
                    n_found       = 1'b0;
                    n_parent_addr = '0;
                    n_parent_rssi = '0;
                    if (r_hit) begin
                        n_add_status = ADD_UPDATED;
                    end else if (r_count < DEPTH_C) begin
                        n_add_status = ADD_INSERTED;
                        n_count      = r_count + 1'b1;
                    end else begin
                        n_add_status = ADD_FULL;
                    end
                end else begin
                    n_add_status  = ADD_UPDATED;
                    n_found       = r_have;
                    n_parent_addr = r_best_addr;
                    n_parent_rssi = r_best_rssi;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_dv    <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dv    <= n_dv;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_cnt      <= n_rd_cnt;
        r_didx        <= n_didx;
        r_func        <= n_func;
        r_key_addr    <= n_key_addr;
        r_key_rssi    <= n_key_rssi;
        r_hit         <= n_hit;
        r_hit_idx     <= n_hit_idx;
        r_have        <= n_have;
        r_best_addr   <= n_best_addr;
        r_best_rssi   <= n_best_rssi;
        r_add_status  <= n_add_status;
        r_found       <= n_found;
        r_parent_addr <= n_parent_addr;
        r_parent_rssi <= n_parent_rssi;
    end

    assign o_done        = r_done;
    assign o_add_status  = r_add_status;
    assign o_found       = r_found;
    assign o_parent_addr = r_parent_addr;
    assign o_parent_rssi = r_parent_rssi;

    // Checks
    `PTBRS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH_C, "entry count overflow")
    `PTBRS_ASSERT_NEXT(a_fin_done, i_clk, i_rst_n, r_state == S_FIN, o_done, "no result after finish")
    `PTBRS_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_FIN, $stable(r_count), "count moved outside finish")
    `PTBRS_ASSERT_NOW(a_found_rssi, i_clk, i_rst_n, o_done && o_found, o_parent_rssi != RSSI_SENTINEL, "sentinel parent chosen")

endmodule
